// ===== src/rdc_pkg.sv =====
`timescale 1ns / 1ps
package rdc_pkg;

  localparam int VALUE_BITS_DEFAULT = 31;
  localparam int RADIX_BITS         = 6;
  localparam int CHAR_BITS          = 7;
  localparam int QUEUE_DEPTH        = 2;

  localparam logic [RADIX_BITS-1:0] RADIX_RESET = 6'd10;
  localparam logic [RADIX_BITS-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_BITS-1:0] RADIX_MAX   = 6'd36;
  localparam logic [RADIX_BITS-1:0] DECIMAL_TOP = 6'd10;
  localparam logic [CHAR_BITS-1:0]  CHAR_ZERO   = 7'd48;
  localparam logic [CHAR_BITS-1:0]  CHAR_ALPHA  = 7'd65;

  // Classification that travels with each queued value
  typedef struct packed {
    logic                  is_zero;
    logic [RADIX_BITS-1:0] base;
  } job_t;

  // Out-of-range register values are clamped into 2..36
  function automatic logic [RADIX_BITS-1:0] effective_base(input logic [RADIX_BITS-1:0] r);
    logic [RADIX_BITS-1:0] b;
    if (r < RADIX_MIN) begin
      b = RADIX_MIN;
    end else if (r > RADIX_MAX) begin
      b = RADIX_MAX;
    end else begin
      b = r;
    end
    return b;
  endfunction

  function automatic logic [CHAR_BITS-1:0] digit_to_ascii(input logic [RADIX_BITS-1:0] d);
    logic [CHAR_BITS-1:0] c;
    if (d < DECIMAL_TOP) begin
      c = CHAR_ZERO + {1'b0, d};
    end else begin
      c = CHAR_ALPHA + {1'b0, d} - {1'b0, DECIMAL_TOP};
    end
    return c;
  endfunction

endpackage

// ===== src/rdc_if.sv =====
`timescale 1ns / 1ps
interface rdc_value_if #(parameter int VALUE_BITS = rdc_pkg::VALUE_BITS_DEFAULT);
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] value;
  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface rdc_digit_if;
  logic                           valid;
  logic                           ready;
  logic [rdc_pkg::CHAR_BITS-1:0]  digit_char;
  logic                           last_digit;
  modport source (output valid, output digit_char, output last_digit, input ready);
  modport sink   (input valid, input digit_char, input last_digit, output ready);
endinterface

interface rdc_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [rdc_pkg::RADIX_BITS-1:0] radix;
  modport source (output valid, output radix, input ready);
  modport sink   (input valid, input radix, output ready);
endinterface

// ===== src/radix_digit_converter_core.sv =====
`timescale 1ns / 1ps
// Channel  Dir  Payload                      Handshake
// -------  ---  ---------------------------  ----------------------------
// number   in   value[VALUE_BITS-1:0]        valid & ready
// digits   out  digit_char[6:0], last_digit  valid & ready, one per digit
// cfg      in   radix[5:0]                   valid & ready (ready tied high)
//
// In the back end each digit is one pass of the bit-serial divider over all
// VALUE_BITS bits of the quotient; the digits are then read back from the digit
// store and loaded into the output register, most significant first. Zero skips the divider.
// Reset clears the sequencer, queue pointers, output valid and sets radix 10;
// the digit store is never cleared (each conversion writes what it reads).
// The two-entry queue keeps taking items while the divider is busy; the
// output register holds a digit under back-pressure without stopping the queue.
module radix_digit_converter_core #(
  parameter int VALUE_BITS = rdc_pkg::VALUE_BITS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  rdc_cfg_if.sink     cfg,
  rdc_value_if.sink   number,
  rdc_digit_if.source digits
);

  // front -> queue
  logic                  fq_valid;
  logic                  fq_ready;
  logic [VALUE_BITS-1:0] fq_value;
  rdc_pkg::job_t         fq_job;

  // queue -> back
  logic                  qb_valid;
  logic                  qb_ready;
  logic [VALUE_BITS-1:0] qb_value;
  rdc_pkg::job_t         qb_job;

  // Front: radix register, base clamp, zero detect
  rdc_front #(
    .VALUE_BITS (VALUE_BITS)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .number  (number),
    .q_valid (fq_valid),
    .q_ready (fq_ready),
    .q_value (fq_value),
    .q_job   (fq_job)
  );

  // Decoupling queue between intake and conversion
  rdc_queue #(
    .VALUE_BITS (VALUE_BITS)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fq_valid),
    .in_ready  (fq_ready),
    .in_value  (fq_value),
    .in_job    (fq_job),
    .out_valid (qb_valid),
    .out_ready (qb_ready),
    .out_value (qb_value),
    .out_job   (qb_job)
  );

  // Back: serial divider, digit store, reverse-order emission
  rdc_back #(
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (qb_valid),
    .job_ready (qb_ready),
    .job_value (qb_value),
    .job       (qb_job),
    .digits    (digits)
  );

endmodule

// ===== src/rdc_ram.sv =====
`timescale 1ns / 1ps
module rdc_ram #(
  parameter int WIDTH = rdc_pkg::RADIX_BITS,
  parameter int DEPTH = rdc_pkg::VALUE_BITS_DEFAULT
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/rdc_front.sv =====
`timescale 1ns / 1ps
module rdc_front #(
  parameter int VALUE_BITS = rdc_pkg::VALUE_BITS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  rdc_cfg_if.sink               cfg,
  rdc_value_if.sink             number,
  output logic                  q_valid,
  input  logic                  q_ready,
  output logic [VALUE_BITS-1:0] q_value,
  output rdc_pkg::job_t         q_job
);

  logic [rdc_pkg::RADIX_BITS-1:0] radix;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= rdc_pkg::RADIX_RESET;
    end else if (cfg.valid) begin
      radix <= cfg.radix;
    end
  end

  // classify: clamp the base once, flag zero so the back end skips division
  assign q_valid       = number.valid;
  assign number.ready  = q_ready;
  assign q_value       = number.value;
  assign q_job.base    = rdc_pkg::effective_base(radix);
  assign q_job.is_zero = (number.value == '0);

endmodule

// ===== src/rdc_queue.sv =====
`timescale 1ns / 1ps
module rdc_queue #(
  parameter int VALUE_BITS = rdc_pkg::VALUE_BITS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [VALUE_BITS-1:0] in_value,
  input  rdc_pkg::job_t         in_job,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [VALUE_BITS-1:0] out_value,
  output rdc_pkg::job_t         out_job
);

  localparam int PW = $clog2(rdc_pkg::QUEUE_DEPTH);
  localparam int CW = $clog2(rdc_pkg::QUEUE_DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(rdc_pkg::QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] FULL     = CW'(rdc_pkg::QUEUE_DEPTH);

  logic [VALUE_BITS-1:0] value_q [rdc_pkg::QUEUE_DEPTH];
  rdc_pkg::job_t         job_q   [rdc_pkg::QUEUE_DEPTH];
  logic [PW-1:0]         wr_ptr;
  logic [PW-1:0]         rd_ptr;
  logic [CW-1:0]         fill;
  logic                  push;
  logic                  pop;

  assign in_ready  = (fill != FULL);
  assign out_valid = (fill != '0);
  assign out_value = value_q[rd_ptr];
  assign out_job   = job_q[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      value_q[wr_ptr] <= in_value;
      job_q[wr_ptr]   <= in_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

  a_no_overfill: assert property (@(posedge clk) disable iff (rst) fill <= FULL)
    else $error("queue fill above depth");

endmodule

// ===== src/rdc_back.sv =====
`timescale 1ns / 1ps
module rdc_back #(
  parameter int VALUE_BITS = rdc_pkg::VALUE_BITS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  job_valid,
  output logic                  job_ready,
  input  logic [VALUE_BITS-1:0] job_value,
  input  rdc_pkg::job_t         job,
  rdc_digit_if.source           digits
);

  localparam int AW = $clog2(VALUE_BITS);
  localparam int CW = $clog2(VALUE_BITS + 1);
  localparam int RB = rdc_pkg::RADIX_BITS;
  localparam logic [AW-1:0] LAST_STEP  = AW'(VALUE_BITS - 1);
  localparam logic [CW-1:0] MAX_DIGITS = CW'(VALUE_BITS);

  localparam logic [1:0] S_IDLE    = 2'd0;
  localparam logic [1:0] S_DIV     = 2'd1;
  localparam logic [1:0] S_EMIT_RD = 2'd2;
  localparam logic [1:0] S_EMIT_WR = 2'd3;

  logic [1:0]            state, state_next;
  logic [VALUE_BITS-1:0] quot, quot_next;
  logic [RB-1:0]         rem, rem_next;
  logic [RB-1:0]         base, base_next;
  logic [AW-1:0]         step, step_next;
  logic [CW-1:0]         cnt, cnt_next;
  logic [AW-1:0]         ptr, ptr_next;
  logic                  out_valid;
  logic [rdc_pkg::CHAR_BITS-1:0] out_char;
  logic                  out_last;

  logic [RB:0]           r2;
  logic [RB:0]           diff;
  logic                  ge;
  logic [RB-1:0]         rem_new;
  logic [VALUE_BITS-1:0] quot_shift;
  logic [CW-1:0]         cnt_inc;
  logic                  load;

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [RB-1:0]         ram_wdata;
  logic                  ram_re;
  logic [RB-1:0]         ram_rdata;

  // one restoring-division step per cycle
  assign r2         = {rem, quot[VALUE_BITS-1]};
  assign ge         = (r2 >= {1'b0, base});
  assign diff       = r2 - {1'b0, base};
  assign rem_new    = ge ? diff[RB-1:0] : r2[RB-1:0];
  assign quot_shift = {quot[VALUE_BITS-2:0], ge};
  assign cnt_inc    = cnt + 1'b1;

  assign job_ready = (state == S_IDLE);
  assign load      = (state == S_EMIT_WR) && (!out_valid || digits.ready);

  always_comb begin
    state_next = state;
    quot_next  = quot;
    rem_next   = rem;
    base_next  = base;
    step_next  = step;
    cnt_next   = cnt;
    ptr_next   = ptr;
    ram_we     = 1'b0;
    ram_waddr  = cnt[AW-1:0];
    ram_wdata  = rem_new;
    ram_re     = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (job_valid) begin
          quot_next = job_value;
          base_next = job.base;
          rem_next  = '0;
          step_next = LAST_STEP;
          if (job.is_zero) begin
            ram_we     = 1'b1;
            ram_waddr  = '0;
            ram_wdata  = '0;
            cnt_next   = CW'(1);
            ptr_next   = '0;
            state_next = S_EMIT_RD;
          end else begin
            cnt_next   = '0;
            state_next = S_DIV;
          end
        end
      end
      S_DIV: begin
        quot_next = quot_shift;
        rem_next  = rem_new;
        step_next = step - 1'b1;
        if (step == '0) begin
          ram_we    = 1'b1;
          cnt_next  = cnt_inc;
          rem_next  = '0;
          step_next = LAST_STEP;
          if (quot_shift == '0 || cnt_inc == MAX_DIGITS) begin
            ptr_next   = cnt[AW-1:0];
            state_next = S_EMIT_RD;
          end
        end
      end
      S_EMIT_RD: begin
        ram_re     = 1'b1;
        state_next = S_EMIT_WR;
      end
      S_EMIT_WR: begin
        if (load) begin
          if (ptr == '0) begin
            state_next = S_IDLE;
          end else begin
            ptr_next   = ptr - 1'b1;
            state_next = S_EMIT_RD;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (digits.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    quot <= quot_next;
    rem  <= rem_next;
    base <= base_next;
    step <= step_next;
    cnt  <= cnt_next;
    ptr  <= ptr_next;
    if (load) begin
      out_char <= rdc_pkg::digit_to_ascii(ram_rdata);
      out_last <= (ptr == '0);
    end
  end

  rdc_ram #(
    .WIDTH (RB),
    .DEPTH (VALUE_BITS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ptr),
    .rdata (ram_rdata)
  );

  assign digits.valid      = out_valid;
  assign digits.digit_char = out_char;
  assign digits.last_digit = out_last;

  a_rem_below_base: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> rem < base)
    else $error("partial remainder not below base");

  a_base_range: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> base >= rdc_pkg::RADIX_MIN && base <= rdc_pkg::RADIX_MAX)
    else $error("working base outside 2..36");

  a_ptr_in_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT_RD || state == S_EMIT_WR) |-> CW'(ptr) < cnt)
    else $error("read pointer beyond stored digits");

  a_div_count: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> cnt < MAX_DIGITS)
    else $error("dividing past digit capacity");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (load && ptr == '0) |=> state == S_IDLE && digits.valid && digits.last_digit)
    else $error("final digit not flagged or sequencer not idle");

endmodule

// ===== verif/radix_digit_checker.sv =====
`timescale 1ns / 1ps
module radix_digit_checker #(
  parameter int VALUE_BITS = rdc_pkg::VALUE_BITS_DEFAULT
) (
  input  logic  clk,
  input  logic  rst,
  rdc_cfg_if    cfg,
  rdc_value_if  number,
  rdc_digit_if  digits,
  output int    mismatches,
  output int    outstanding
);

  localparam int CB = rdc_pkg::CHAR_BITS;
  localparam int RB = rdc_pkg::RADIX_BITS;

  typedef struct packed {
    logic [CB-1:0] digit_char;
    logic          last_digit;
  } digit_t;

  digit_t        digits_due[$];
  logic [RB-1:0] radix_q = rdc_pkg::RADIX_RESET;
  int            errors  = 0;

  // Queues the characters of v in base r, most significant first
  function automatic void convert_to_digits(input logic [VALUE_BITS-1:0] v,
                                            input logic [RB-1:0] r);
    logic [RB-1:0]         base;
    logic [VALUE_BITS-1:0] rest;
    logic [RB-1:0]         rems[$];
    logic [RB-1:0]         d;
    digit_t                ch;
    // out-of-range settings clamp into 2..36
    if (r < rdc_pkg::RADIX_MIN) begin
      base = rdc_pkg::RADIX_MIN;
    end else if (r > rdc_pkg::RADIX_MAX) begin
      base = rdc_pkg::RADIX_MAX;
    end else begin
      base = r;
    end
    rest = v;
    do begin
      rems.push_back(RB'(rest % base));
      rest = rest / base;
    end while (rest != 0);
    while (rems.size() != 0) begin
      d = rems.pop_back();
      if (d < rdc_pkg::DECIMAL_TOP) begin
        ch.digit_char = rdc_pkg::CHAR_ZERO + CB'(d);
      end else begin
        ch.digit_char = rdc_pkg::CHAR_ALPHA + CB'(d - rdc_pkg::DECIMAL_TOP);
      end
      ch.last_digit = (rems.size() == 0);
      digits_due.push_back(ch);
    end
  endfunction

  always @(posedge clk) begin : watch
    digit_t want;
    if (rst) begin
      digits_due.delete();
      radix_q = rdc_pkg::RADIX_RESET;
    end else begin
      if ((digits.valid & digits.ready) === 1'b1) begin
        if (digits_due.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t ns: digit with none due: char %0d last %0b", $realtime,
                     digits.digit_char, digits.last_digit);
        end else begin
          want = digits_due.pop_front();
          if (digits.digit_char !== want.digit_char ||
              digits.last_digit !== want.last_digit) begin
            errors++;
            if (errors <= 10)
              $display("%0t ns: digit mismatch: expected char %0d last %0b, %s %0d last %0b",
                       $realtime, want.digit_char, want.last_digit, "got char",
                       digits.digit_char, digits.last_digit);
          end
        end
      end
      if ((number.valid & number.ready) === 1'b1)
        convert_to_digits(number.value, radix_q);
      if ((cfg.valid & cfg.ready) === 1'b1)
        radix_q = cfg.radix;
    end
    mismatches  <= errors;
    outstanding <= digits_due.size();
  end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
module tb;

  localparam int            VB          = rdc_pkg::VALUE_BITS_DEFAULT;
  localparam int            RB          = rdc_pkg::RADIX_BITS;
  localparam logic [VB-1:0] VALUE_MAX   = '1;
  // allows for the longest (31-digit) conversion plus receiver stalls, with a generous margin
  localparam int            IDLE_LIMIT  = 20000;
  localparam int            TAIL_CYCLES = 100;

  // receiver stall styles
  typedef enum int {RX_OPEN, RX_LIGHT, RX_HALF, RX_HEAVY} rx_mode_t;

  logic clk;
  logic rst;
  int   fail_count;
  int   digits_pending;
  int   burst_left = 0;

  rdc_cfg_if                         cfg_ch ();
  rdc_value_if #(.VALUE_BITS(VB))    number_ch ();
  rdc_digit_if                       digits_ch ();

  radix_digit_converter_core #(.VALUE_BITS(VB)) u_top (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_ch),
    .number (number_ch),
    .digits (digits_ch)
  );

  // Watches all three channels, predicts the digit stream and compares it
  radix_digit_checker #(.VALUE_BITS(VB)) u_check (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg_ch),
    .number      (number_ch),
    .digits      (digits_ch),
    .mismatches  (fail_count),
    .outstanding (digits_pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Any handshake on any channel counts as progress for the watchdog
  logic progress;
  assign progress = ((number_ch.valid & number_ch.ready) === 1'b1) ||
                    ((digits_ch.valid & digits_ch.ready) === 1'b1) ||
                    ((cfg_ch.valid & cfg_ch.ready) === 1'b1);

  // Send one value. Items go out in bursts; a gap (valid low) may open
  // before a new burst. Valid is only lowered when a gap actually starts,
  // so back-to-back items never see valid dropped and raised in one step.
  task automatic send_value(input logic [VB-1:0] v);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
      burst_left = $urandom_range(1, 12);
      if (gap != 0) begin
        number_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    number_ch.valid <= 1'b1;
    number_ch.value <= v;
    do @(posedge clk); while (number_ch.ready !== 1'b1);
    burst_left--;
  endtask

  // Stop sending and wait until every predicted digit has come out.
  // It lets the checker see the last item go in before it watches the pending count.
  task automatic settle();
    number_ch.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (digits_pending != 0) @(posedge clk);
  endtask

  // New base, written only with the converter drained
  task automatic retune(input logic [RB-1:0] r);
    settle();
    cfg_ch.valid <= 1'b1;
    cfg_ch.radix <= r;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    cfg_ch.valid <= 1'b0;
  endtask

  // Mix of full-width, truncated-width, small and corner values.
  // Full-width and truncated-width values are the most common, so every bit of value is exercised.
  function automatic logic [VB-1:0] pick_value();
    logic [VB-1:0] v;
    case ($urandom_range(0, 9))
      0:       v = '0;
      1:       v = VALUE_MAX;
      2, 3, 4: v = VB'($urandom);
      5, 6, 7: v = VB'($urandom >> $urandom_range(0, 30));
      default: v = VB'($urandom_range(0, 2000));
    endcase
    return v;
  endfunction

  // Receiver: stretches of a random stall style, including fully open ones
  initial begin : receiver
    rx_mode_t mode;
    int       span;
    digits_ch.ready <= 1'b0;
    forever begin
      mode = rx_mode_t'($urandom_range(0, 3));
      span = $urandom_range(5, 60);
      repeat (span) begin
        @(posedge clk);
        case (mode)
          RX_OPEN:  digits_ch.ready <= 1'b1;
          RX_LIGHT: digits_ch.ready <= ($urandom_range(0, 3) != 0);
          RX_HALF:  digits_ch.ready <= 1'($urandom_range(0, 1));
          default:  digits_ch.ready <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  // Watchdog: too long with no handshake anywhere means the block has hung
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if (progress) quiet = 0;
      else          quiet++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : stimulus
    int p;
    cfg_ch.valid    <= 1'b0;
    cfg_ch.radix    <= rdc_pkg::RADIX_RESET;
    number_ch.valid <= 1'b0;
    number_ch.value <= '0;
    rst             <= 1'b1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Decimal straight out of reset: zero, single digits, carry into two, max
    send_value(VB'(0));
    send_value(VB'(1));
    send_value(VB'(9));
    send_value(VB'(10));
    send_value(VALUE_MAX);

    // Base 36: top letter, first two-digit value, all-'Z' strings
    retune(rdc_pkg::RADIX_MAX);
    send_value(VB'(35));
    send_value(VB'(36));
    send_value(VB'(1295));
    send_value(VB'(60466175));
    send_value(VALUE_MAX);

    // Binary: longest strings (31 digits)
    retune(rdc_pkg::RADIX_MIN);
    send_value(VB'(0));
    send_value(VB'(1));
    send_value(VB'(1) << (VB - 1));
    send_value(VALUE_MAX);

    // Settings below two behave as binary
    retune(6'd0);
    send_value(VB'(5));
    send_value(VALUE_MAX);
    retune(6'd1);
    send_value(VB'(6));

    // Settings above thirty-six behave as base 36
    retune(6'd37);
    send_value(VB'(35));
    send_value(VB'(0));
    retune(6'd63);
    send_value(VB'(1295));
    send_value(VALUE_MAX);

    // Hex with letters A..E in it
    retune(6'd16);
    send_value(VB'(32'h7EDC_BA98));

    // Random bases, random values
    for (p = 0; p < 6; p++) begin
      retune(RB'($urandom_range(0, 63)));
      repeat (18) send_value(pick_value());
    end

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && digits_pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/rdc_pkg.sv
src/rdc_if.sv
src/rdc_ram.sv
src/rdc_front.sv
src/rdc_queue.sv
src/rdc_back.sv
src/radix_digit_converter_core.sv
verif/radix_digit_checker.sv
verif/tb.sv
